>>> rtl/core/lsf_pkg.sv
// Shared types, constants and helpers of the least-squares line fit block.
`default_nettype none

package lsf_pkg;

    // Default capacity of the point store
    localparam int DEF_MAX_POINTS = 16;

    // Width of one coordinate
    localparam int PT_W = 16;

    // Working width of the fit arithmetic; it holds every product of the sums
    // for a store of up to 256 points
    localparam int WIDE_W = 64;

    // Dividend width: working width plus the intercept's fraction shift
    localparam int DVD_W = WIDE_W + 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // What the back does with a queued point
    typedef enum logic
    {
        KIND_STORE,
        KIND_DROP
    } kind_t;

    // One queued point
    typedef struct packed
    {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        kind_t                  kind;
        logic                   last;
    } q_item_t;

    // Back-end sequencer states
    typedef enum logic [3:0]
    {
        BK_ACCUM,
        BK_MUL_GO,
        BK_MUL_WAIT,
        BK_CHECK,
        BK_DIV1_GO,
        BK_DIV1_WAIT,
        BK_DIV2_GO,
        BK_DIV2_WAIT,
        BK_RES_RD,
        BK_RES_MUL,
        BK_RES_ACC,
        BK_FINISH,
        BK_OUT
    } back_state_t;

    // Queue status seen by the front
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

    // Turn a quotient magnitude into a saturated signed Q15.16 (slope) or
    // Q23.8 (intercept) value; the top bit of the result is the saturation flag.
    // A negative magnitude of exactly 2^31 is the most negative value, not saturated.
    function automatic logic [32:0] fix_quot(input logic [DVD_W-1:0] q, input logic neg);
        logic        sat;
        logic [31:0] val;
        sat = (|q[DVD_W-1:32]) || (q[31] && (!neg || (|q[30:0])));
        if (sat)
        begin
            val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            val = neg ? (32'd0 - q[31:0]) : q[31:0];
        end
        return {sat, val};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/least_squares_line_fit.sv
// Top level of the least-squares line fit block.
//
//  channel   dir  width  contents (low bit up)
//  s_axis    in   32+1   tdata: point_x, point_y; tlast: last_point
//  m_axis    out  96     tdata: slope, intercept, residual_sum, fit_status, zero pad
//
// Points are taken one per cycle while the queue between front and back has room.
// After the last point the fit runs six products on the shift-add multiplier,
// then, unless the sums are singular, two quotients on the restoring divider
// and a pass per stored point through the point store read port.
// Reset clears sums, count and queue; the point store itself is not cleared.
// A stalled result holds in the output register while new points keep queuing.
`default_nettype none

module least_squares_line_fit #(
    parameter int MAX_POINTS = lsf_pkg::DEF_MAX_POINTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // point_x [15:0], point_y [31:16]
    input  wire logic        s_axis_tlast,   // last_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata    // slope, intercept, residual_sum, fit_status
);

    lsf_pkg::q_status_t q_status;
    lsf_pkg::q_item_t   push_item;
    lsf_pkg::q_item_t   pop_item;
    logic               push;
    logic               pop;

    lsf_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    lsf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    lsf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/lsf_front.sv
// Input front end: accepts points and classifies them as stored or dropped.
`default_nettype none

module lsf_front #(
    parameter int MAX_POINTS = lsf_pkg::DEF_MAX_POINTS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [31:0]      s_axis_tdata,
    input  wire logic             s_axis_tlast,
    input  wire lsf_pkg::q_status_t q_status,
    output logic                  push,
    output lsf_pkg::q_item_t      push_item
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          full_set;

    // Take a transaction whenever the queue has room
    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && !q_status.full;
    assign full_set      = (cnt_reg == CW'(MAX_POINTS));

    // Classify the point
    always_comb
    begin
        push_item.x    = s_axis_tdata[15:0];
        push_item.y    = s_axis_tdata[31:16];
        push_item.kind = full_set ? lsf_pkg::KIND_DROP : lsf_pkg::KIND_STORE;
        push_item.last = s_axis_tlast;
    end

    // Track the stored count of the current set
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (s_axis_tlast)
            begin
                cnt_next = '0;
            end
            else if (!full_set)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lsf_fifo.sv
// Short queue of classified points between front and back.
`default_nettype none

module lsf_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lsf_pkg::q_item_t  push_item,
    input  wire logic              pop,
    output lsf_pkg::q_item_t       pop_item,
    output lsf_pkg::q_status_t     q_status
);

    localparam int DEPTH = lsf_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsf_pkg::q_item_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign q_status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign pop_item       = slot_reg[rd_ptr_reg];

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lsf_mul.sv
// Sequential shift-add multiplier, one operand bit per cycle, product mod 2^WIDE_W.
`default_nettype none

module lsf_mul (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [lsf_pkg::WIDE_W-1:0]  a,
    input  wire logic signed [lsf_pkg::WIDE_W-1:0]  b,
    output logic                                    done,
    output logic signed [lsf_pkg::WIDE_W-1:0]       p
);

    localparam int W  = lsf_pkg::WIDE_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  p_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    assign done = done_reg;
    assign p    = p_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Add the shifted multiplicand for each set bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            p_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lsf_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lsf_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lsf_pkg::DVD_W-1:0]   dvd,
    input  wire logic [lsf_pkg::WIDE_W-1:0]  den,
    output logic                             done,
    output logic [lsf_pkg::DVD_W-1:0]        q
);

    localparam int W  = lsf_pkg::WIDE_W;
    localparam int DW = lsf_pkg::DVD_W;
    localparam int CW = $clog2(DW);

    logic [W:0]    rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] q_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic          fits;

    assign done  = done_reg;
    assign q     = q_reg;
    assign trial = {rem_reg[W-1:0], dvd_reg[DW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit and try a subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dvd;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lsf_back.sv
// Back end: accumulates points, solves the fit, walks residuals, holds the result.
`default_nettype none

module lsf_back #(
    parameter int MAX_POINTS = lsf_pkg::DEF_MAX_POINTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsf_pkg::q_status_t q_status,
    input  wire lsf_pkg::q_item_t   pop_item,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [95:0]             m_axis_tdata
);

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int SX_W = lsf_pkg::PT_W + CW;
    localparam int SQ_W = 2 * lsf_pkg::PT_W + CW;
    localparam int W    = lsf_pkg::WIDE_W;
    localparam int DW   = lsf_pkg::DVD_W;

    lsf_pkg::back_state_t state_reg;
    lsf_pkg::back_state_t state_next;

    // Accumulator state
    logic [CW-1:0]          n_reg;
    logic signed [SX_W-1:0] sx_reg;
    logic signed [SX_W-1:0] sy_reg;
    logic signed [SQ_W-1:0] sxx_reg;
    logic signed [SQ_W-1:0] sxy_reg;
    logic                   ovf_reg;

    // Point store
    logic [31:0] mem [MAX_POINTS];
    logic [31:0] rd_data_reg;
    logic        wr_en;

    // Fit datapath
    logic [2:0]             sel_reg;
    logic signed [W-1:0]    p_reg [6];
    logic signed [31:0]     slope_reg;
    logic signed [31:0]     icpt_reg;
    logic                   sat_reg;
    logic                   sing_reg;
    logic [CW-1:0]          ridx_reg;
    logic signed [47:0]     prod_reg;
    logic signed [15:0]     py_reg;
    logic [W-1:0]           acc_reg;
    logic [23:0]            rsum_reg;
    logic [1:0]             status_reg;

    logic                   m_valid_reg;
    logic [95:0]            m_data_reg;

    logic                   mul_start;
    logic signed [W-1:0]    mul_a;
    logic signed [W-1:0]    mul_b;
    logic                   mul_done;
    logic signed [W-1:0]    mul_p;
    logic                   div_start;
    logic [DW-1:0]          div_dvd;
    logic                   div_done;
    logic [DW-1:0]          div_q;

    logic signed [W-1:0]    det;
    logic signed [W-1:0]    num1;
    logic signed [W-1:0]    num2;
    logic [W-1:0]           mag1;
    logic [W-1:0]           mag2;
    logic                   singular;
    logic signed [31:0]     xx;
    logic signed [31:0]     xy;
    logic signed [W-1:0]    resid;
    logic [W-1:0]           resid_mag;
    logic [32:0]            fq;
    logic                   out_free;
    logic                   ridx_end;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Normal-equation terms
    assign det      = p_reg[0] - p_reg[1];
    assign num1     = p_reg[2] - p_reg[3];
    assign num2     = p_reg[4] - p_reg[5];
    assign mag1     = num1[W-1] ? (W'(0) - num1) : num1;
    assign mag2     = num2[W-1] ? (W'(0) - num2) : num2;
    assign singular = (n_reg < CW'(2)) || (det <= 0);

    assign xx = pop_item.x * pop_item.x;
    assign xy = pop_item.x * pop_item.y;

    // Residual of one point in Q16
    assign resid = (W'(py_reg) <<< 16) - W'(prod_reg) - (W'(icpt_reg) <<< 8);
    assign resid_mag = resid[W-1] ? (W'(0) - resid) : resid;
    assign ridx_end  = ((ridx_reg + CW'(1)) == n_reg);

    assign fq = lsf_pkg::fix_quot(div_q, (state_reg == lsf_pkg::BK_DIV1_WAIT) ? num1[W-1]
                                                                             : num2[W-1]);

    // Multiplier operand select
    always_comb
    begin
        unique case (sel_reg)
            3'd0:
            begin
                mul_a = W'(n_reg);
                mul_b = W'(sxx_reg);
            end
            3'd1:
            begin
                mul_a = W'(sx_reg);
                mul_b = W'(sx_reg);
            end
            3'd2:
            begin
                mul_a = W'(n_reg);
                mul_b = W'(sxy_reg);
            end
            3'd3:
            begin
                mul_a = W'(sx_reg);
                mul_b = W'(sy_reg);
            end
            3'd4:
            begin
                mul_a = W'(sy_reg);
                mul_b = W'(sxx_reg);
            end
            default:
            begin
                mul_a = W'(sx_reg);
                mul_b = W'(sxy_reg);
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsf_pkg::BK_ACCUM:
            begin
                if (!q_status.empty && pop_item.last)
                begin
                    state_next = lsf_pkg::BK_MUL_GO;
                end
            end
            lsf_pkg::BK_MUL_GO:
            begin
                state_next = lsf_pkg::BK_MUL_WAIT;
            end
            lsf_pkg::BK_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (sel_reg == 3'd5) ? lsf_pkg::BK_CHECK : lsf_pkg::BK_MUL_GO;
                end
            end
            lsf_pkg::BK_CHECK:
            begin
                state_next = singular ? lsf_pkg::BK_FINISH : lsf_pkg::BK_DIV1_GO;
            end
            lsf_pkg::BK_DIV1_GO:
            begin
                state_next = lsf_pkg::BK_DIV1_WAIT;
            end
            lsf_pkg::BK_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lsf_pkg::BK_DIV2_GO;
                end
            end
            lsf_pkg::BK_DIV2_GO:
            begin
                state_next = lsf_pkg::BK_DIV2_WAIT;
            end
            lsf_pkg::BK_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lsf_pkg::BK_RES_RD;
                end
            end
            lsf_pkg::BK_RES_RD:
            begin
                state_next = lsf_pkg::BK_RES_MUL;
            end
            lsf_pkg::BK_RES_MUL:
            begin
                state_next = lsf_pkg::BK_RES_ACC;
            end
            lsf_pkg::BK_RES_ACC:
            begin
                state_next = ridx_end ? lsf_pkg::BK_FINISH : lsf_pkg::BK_RES_RD;
            end
            lsf_pkg::BK_FINISH:
            begin
                state_next = lsf_pkg::BK_OUT;
            end
            lsf_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = lsf_pkg::BK_ACCUM;
                end
            end
            default:
            begin
                state_next = lsf_pkg::BK_ACCUM;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop       = (state_reg == lsf_pkg::BK_ACCUM) && !q_status.empty;
        wr_en     = pop && (pop_item.kind == lsf_pkg::KIND_STORE);
        mul_start = (state_reg == lsf_pkg::BK_MUL_GO);
        div_start = (state_reg == lsf_pkg::BK_DIV1_GO) || (state_reg == lsf_pkg::BK_DIV2_GO);
        if (state_reg == lsf_pkg::BK_DIV1_GO)
        begin
            div_dvd = DW'(mag1) << 16;
        end
        else
        begin
            div_dvd = DW'(mag2) << 8;
        end
    end

    // Store points and read one per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[n_reg[AW-1:0]] <= {pop_item.y, pop_item.x};
        end
        rd_data_reg <= mem[ridx_reg[AW-1:0]];
    end

    // Control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lsf_pkg::BK_ACCUM;
            n_reg       <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxx_reg     <= '0;
            sxy_reg     <= '0;
            ovf_reg     <= 1'b0;
            sel_reg     <= '0;
            ridx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Raise valid when the result is loaded, drop it once taken
            if ((state_reg == lsf_pkg::BK_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                lsf_pkg::BK_ACCUM:
                begin
                    sel_reg <= '0;
                    if (wr_en)
                    begin
                        n_reg   <= n_reg + CW'(1);
                        sx_reg  <= sx_reg + SX_W'(pop_item.x);
                        sy_reg  <= sy_reg + SX_W'(pop_item.y);
                        sxx_reg <= sxx_reg + SQ_W'(xx);
                        sxy_reg <= sxy_reg + SQ_W'(xy);
                    end
                    else if (pop)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                lsf_pkg::BK_MUL_WAIT:
                begin
                    if (mul_done && (sel_reg != 3'd5))
                    begin
                        sel_reg <= sel_reg + 3'd1;
                    end
                end
                lsf_pkg::BK_CHECK:
                begin
                    ridx_reg <= '0;
                end
                lsf_pkg::BK_RES_ACC:
                begin
                    ridx_reg <= ridx_reg + CW'(1);
                end
                lsf_pkg::BK_OUT:
                begin
                    if (out_free)
                    begin
                        n_reg       <= '0;
                        sx_reg      <= '0;
                        sy_reg      <= '0;
                        sxx_reg     <= '0;
                        sxy_reg     <= '0;
                        ovf_reg     <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Fit payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lsf_pkg::BK_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    p_reg[sel_reg] <= mul_p;
                end
            end
            lsf_pkg::BK_CHECK:
            begin
                slope_reg <= '0;
                icpt_reg  <= '0;
                acc_reg   <= '0;
                sat_reg   <= 1'b0;
                sing_reg  <= singular;
            end
            lsf_pkg::BK_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    slope_reg <= fq[31:0];
                    sat_reg   <= sat_reg | fq[32];
                end
            end
            lsf_pkg::BK_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    icpt_reg <= fq[31:0];
                    sat_reg  <= sat_reg | fq[32];
                end
            end
            lsf_pkg::BK_RES_MUL:
            begin
                prod_reg <= slope_reg * $signed(rd_data_reg[15:0]);
                py_reg   <= rd_data_reg[31:16];
            end
            lsf_pkg::BK_RES_ACC:
            begin
                acc_reg <= acc_reg + resid_mag;
            end
            lsf_pkg::BK_FINISH:
            begin
                rsum_reg <= (|acc_reg[W-1:40]) ? 24'hFF_FFFF : acc_reg[39:16];
                priority if (sing_reg)
                begin
                    status_reg <= lsf_pkg::ST_SINGULAR;
                end
                else if (ovf_reg)
                begin
                    status_reg <= lsf_pkg::ST_DROPPED;
                end
                else if (sat_reg || (|acc_reg[W-1:40]))
                begin
                    status_reg <= lsf_pkg::ST_SAT;
                end
                else
                begin
                    status_reg <= lsf_pkg::ST_OK;
                end
            end
            lsf_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg <= {6'd0, status_reg, rsum_reg, icpt_reg, slope_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    lsf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    lsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (div_dvd),
        .den   (W'(det)),
        .done  (div_done),
        .q     (div_q)
    );

endmodule

`default_nettype wire
